// File: rtl/agll_pkg.sv
// ----------------------------------------------------------------------------
// agll_pkg - shared types, constants and helpers
// Widths, operand and post-operation codes, the micro-op table and the
// saturating arithmetic used by the likelihood gradient core.
// ----------------------------------------------------------------------------
`default_nettype none

package agll_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 64;
  localparam int IN_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int GRAD_W     = 64;
  localparam int NUM_GRAD   = 6;
  localparam int OUT_TDATA_W = GRAD_W * NUM_GRAD;
  localparam int ERR_W      = 40;
  localparam int DER_W      = 48;
  localparam int VAR_W      = 48;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_W     = 31;
  localparam int PC_W       = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MEAN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GCONST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GARCH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INITV = 3'd6;

  localparam logic signed [63:0] ONE_Q16 = 64'sd65536;
  localparam logic signed [63:0] VAR_MAX = (64'sd1 <<< VAR_W) - 64'sd1;
  localparam logic signed [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  // last micro-op of the recursion, first after the divisions, last overall
  localparam logic [PC_W-1:0] PC_REC_END = 5'd19;
  localparam logic [PC_W-1:0] PC_QQ      = 5'd20;
  localparam logic [PC_W-1:0] PC_END     = 5'd29;

  typedef enum logic [3:0] {
    OP_PE, OP_PS, OP_MA, OP_AR, OP_ARCH, OP_GARCH, OP_TMP, OP_ESQ,
    OP_PV, OP_Q, OP_DIFF, OP_EDK, OP_VDK, OP_VDK3
  } opsel_e;

  typedef enum logic [3:0] {
    PO_ESQ, PO_TMP, PO_XHAT, PO_S1, PO_S2, PO_DS, PO_DE, PO_DS3, PO_QQ, PO_SUM,
    PO_SUM3
  } post_e;

  typedef struct packed {
    logic                sat;
    logic signed [63:0]  v;
  } sat_t;

  typedef struct packed {
    opsel_e      a;
    opsel_e      b;
    logic [5:0]  sh;
    post_e       post;
    logic [1:0]  k;
  } uop_t;

  typedef struct packed {
    logic  load;
    logic  init_first;
    logic  mul_start;
    uop_t  uop;
    logic  clamp_s;
    logic  div_start;
    logic  div_sel;
    logic  fin;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } sts_t;

  function automatic sat_t add_sat(input logic signed [63:0] a,
                                   input logic signed [63:0] b);
    sat_t r;
    logic signed [63:0] s;
    s = a + b;
    r.sat = 1'b0;
    r.v   = s;
    if (a[63] == b[63] && s[63] != a[63]) begin
      r.sat = 1'b1;
      r.v   = a[63] ? S64_MIN : S64_MAX;
    end
    return r;
  endfunction

  function automatic sat_t clamp_w(input logic signed [63:0] v, input int w);
    sat_t r;
    logic signed [63:0] lim;
    logic signed [63:0] hi;
    lim = (64'sd1 <<< (w - 1)) - 64'sd1;
    hi  = v >>> (w - 1);
    r.sat = 1'b0;
    r.v   = v;
    if (hi != 64'sd0 && hi != -64'sd1) begin
      r.sat = 1'b1;
      r.v   = v[63] ? (-lim - 64'sd1) : lim;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic uop_t mk(input opsel_e a, input opsel_e b, input logic [5:0] sh,
                              input post_e post, input logic [1:0] k);
    uop_t u;
    u.a = a; u.b = b; u.sh = sh; u.post = post; u.k = k;
    return u;
  endfunction

  // Micro-op table: recursion (0..19), then e/s squared (20), then the sums;
  // the variance-weight sums (27..29) have no error-derivative part
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = mk(OP_PE,    OP_PE,   6'd16, PO_ESQ,  2'd0);
      5'd1:  u = mk(OP_MA,    OP_PE,   6'd30, PO_TMP,  2'd0);
      5'd2:  u = mk(OP_AR,    OP_PS,   6'd30, PO_XHAT, 2'd0);
      5'd3:  u = mk(OP_ARCH,  OP_ESQ,  6'd30, PO_S1,   2'd0);
      5'd4:  u = mk(OP_GARCH, OP_PV,   6'd30, PO_S2,   2'd0);
      5'd5:  u = mk(OP_PE,    OP_EDK,  6'd15, PO_TMP,  2'd0);
      5'd6:  u = mk(OP_ARCH,  OP_TMP,  6'd30, PO_TMP,  2'd0);
      5'd7:  u = mk(OP_GARCH, OP_VDK,  6'd30, PO_DS,   2'd0);
      5'd8:  u = mk(OP_MA,    OP_EDK,  6'd30, PO_DE,   2'd0);
      5'd9:  u = mk(OP_GARCH, OP_VDK3, 6'd30, PO_DS3,  2'd0);
      5'd10: u = mk(OP_PE,    OP_EDK,  6'd15, PO_TMP,  2'd1);
      5'd11: u = mk(OP_ARCH,  OP_TMP,  6'd30, PO_TMP,  2'd1);
      5'd12: u = mk(OP_GARCH, OP_VDK,  6'd30, PO_DS,   2'd1);
      5'd13: u = mk(OP_MA,    OP_EDK,  6'd30, PO_DE,   2'd1);
      5'd14: u = mk(OP_GARCH, OP_VDK3, 6'd30, PO_DS3,  2'd1);
      5'd15: u = mk(OP_PE,    OP_EDK,  6'd15, PO_TMP,  2'd2);
      5'd16: u = mk(OP_ARCH,  OP_TMP,  6'd30, PO_TMP,  2'd2);
      5'd17: u = mk(OP_GARCH, OP_VDK,  6'd30, PO_DS,   2'd2);
      5'd18: u = mk(OP_MA,    OP_EDK,  6'd30, PO_DE,   2'd2);
      5'd19: u = mk(OP_GARCH, OP_VDK3, 6'd30, PO_DS3,  2'd2);
      5'd20: u = mk(OP_Q,     OP_Q,    6'd32, PO_QQ,   2'd0);
      5'd21: u = mk(OP_Q,     OP_EDK,  6'd15, PO_TMP,  2'd0);
      5'd22: u = mk(OP_VDK,   OP_DIFF, 6'd16, PO_SUM,  2'd0);
      5'd23: u = mk(OP_Q,     OP_EDK,  6'd15, PO_TMP,  2'd1);
      5'd24: u = mk(OP_VDK,   OP_DIFF, 6'd16, PO_SUM,  2'd1);
      5'd25: u = mk(OP_Q,     OP_EDK,  6'd15, PO_TMP,  2'd2);
      5'd26: u = mk(OP_VDK,   OP_DIFF, 6'd16, PO_SUM,  2'd2);
      5'd27: u = mk(OP_VDK3,  OP_DIFF, 6'd16, PO_SUM3, 2'd0);
      5'd28: u = mk(OP_VDK3,  OP_DIFF, 6'd16, PO_SUM3, 2'd1);
      5'd29: u = mk(OP_VDK3,  OP_DIFF, 6'd16, PO_SUM3, 2'd2);
      default: u = mk(OP_PE,  OP_PE,   6'd16, PO_TMP,  2'd0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: rtl/agll_mul.sv
// ----------------------------------------------------------------------------
// agll_mul - shared multiply-and-shift unit
// Signed 64x64 product built from four 32x32 partial products, then shifted
// right with magnitude truncation and clamped to +-(2^63-1).
// ----------------------------------------------------------------------------
`default_nettype none

module agll_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  input  wire logic [5:0]         sh_i,
  output logic signed [63:0]      res_o,
  output logic                    sat_o,
  output logic                    done_o
);

  logic         busy_q, busy_d;
  logic [2:0]   cnt_q, cnt_d;
  logic         done_q, done_d;
  logic [63:0]  ma_q, mb_q;
  logic         neg_q;
  logic [5:0]   sh_q;
  logic [127:0] acc_q, acc_d;
  logic signed [63:0] res_q, res_d;
  logic         sat_q, sat_d;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] m_full;
  logic [63:0]  m_val;
  logic         m_sat;

  function automatic logic [63:0] S64MAX_U();
    return 64'(agll_pkg::S64_MAX);
  endfunction

  always_comb begin
    ah = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    bh = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    pp = ah * bh;
    case ({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    m_full = acc_q >> sh_q;
    m_sat  = |m_full[127:63];
    m_val  = m_sat ? S64MAX_U() : m_full[63:0];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    res_d  = res_q;
    sat_d  = sat_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      acc_d  = '0;
    end else if (busy_q) begin
      if (cnt_q[2]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? -$signed(m_val) : $signed(m_val);
        sat_d  = m_sat;
      end else begin
        acc_d = acc_q + pp_sh;
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    res_q <= res_d;
    sat_q <= sat_d;
    if (start_i) begin
      ma_q  <= agll_pkg::mag64(a_i);
      mb_q  <= agll_pkg::mag64(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      sh_q  <= sh_i;
    end
  end

  assign res_o  = res_q;
  assign sat_o  = sat_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: rtl/agll_div.sv
// ----------------------------------------------------------------------------
// agll_div - serial restoring divider
// 128-bit dividend by a 48-bit divisor, one quotient bit per cycle; the
// quotient clamps to 2^63-1.
// ----------------------------------------------------------------------------
`default_nettype none

module agll_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [127:0]             dvd_i,
  input  wire logic [agll_pkg::VAR_W-1:0] dvs_i,
  output logic [63:0]                   quo_o,
  output logic                          sat_o,
  output logic                          done_o
);

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [127:0] dvd_q, dvd_d;
  logic [agll_pkg::VAR_W-1:0] dvs_q, rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic        ovf_q, ovf_d;
  logic [agll_pkg::VAR_W:0] trial;
  logic        ge;

  always_comb begin
    trial  = {rem_q, dvd_q[127]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dvd_i;
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[126:0], 1'b0};
      ovf_d = ovf_q | quo_q[63] | quo_q[62];
      quo_d = {quo_q[62:0], ge};
      rem_d = ge ? agll_pkg::VAR_W'(trial - {1'b0, dvs_q})
                 : trial[agll_pkg::VAR_W-1:0];
      cnt_d = cnt_q + 7'd1;
      if (&cnt_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
    if (start_i) begin
      dvs_q <= dvs_i;
    end
  end

  assign sat_o  = ovf_q | quo_q[63];
  assign quo_o  = sat_o ? 64'(agll_pkg::S64_MAX) : quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: rtl/agll_ctrl.sv
// ----------------------------------------------------------------------------
// agll_ctrl - sequencer
// Steps one sample through setup, the micro-op table, the two divisions and
// the final update, and owns both stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module agll_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire agll_pkg::sts_t sts_i,
  output agll_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FIRST = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_MWAIT = 4'd3;
  localparam logic [3:0] ST_CLAMP = 4'd4;
  localparam logic [3:0] ST_DIVQ  = 4'd5;
  localparam logic [3:0] ST_DWQ   = 4'd6;
  localparam logic [3:0] ST_DIVR  = 4'd7;
  localparam logic [3:0] ST_DWR   = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [agll_pkg::PC_W-1:0] pc_q, pc_d;
  logic first_q, first_d;
  logic last_q, last_d;
  logic oval_q, oval_d;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    first_d = first_q;
    last_d  = last_q;
    oval_d  = oval_q & ~out_ready_i;
    in_ready_o = 1'b0;
    cmd_o = '0;
    cmd_o.uop  = agll_pkg::uop_rom(pc_q);
    cmd_o.last = last_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          last_d = in_last_i;
          pc_d   = '0;
          state_d = first_q ? ST_FIRST : ST_MUL;
        end
      end
      ST_FIRST: begin
        cmd_o.init_first = 1'b1;
        state_d = ST_CLAMP;
      end
      ST_MUL: begin
        cmd_o.mul_start = 1'b1;
        state_d = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (sts_i.mul_done) begin
          if (pc_q == agll_pkg::PC_REC_END) begin
            state_d = ST_CLAMP;
          end else if (pc_q == agll_pkg::PC_END) begin
            state_d = ST_FIN;
          end else begin
            pc_d = pc_q + 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_CLAMP: begin
        cmd_o.clamp_s = 1'b1;
        state_d = ST_DIVQ;
      end
      ST_DIVQ: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DWQ;
      end
      ST_DWQ: begin
        if (sts_i.div_done) begin
          state_d = ST_DIVR;
        end
      end
      ST_DIVR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d = ST_DWR;
      end
      ST_DWR: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          pc_d = agll_pkg::PC_QQ;
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        // hold a result until the previous one has been taken
        if (!(last_q && oval_q && !out_ready_i)) begin
          cmd_o.fin = 1'b1;
          first_d = last_q;
          if (last_q) begin
            oval_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      first_q <= 1'b1;
      last_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      first_q <= first_d;
      last_q  <= last_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o = oval_q;

endmodule

`default_nettype wire

// File: rtl/agll_datapath.sv
// ----------------------------------------------------------------------------
// agll_datapath - recursion state, registers and arithmetic
// Holds the model coefficients, the series state and the running sums, and
// applies each micro-op result through the saturating adders.
// ----------------------------------------------------------------------------
`default_nettype none

module agll_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire agll_pkg::cmd_t                      cmd_i,
  output agll_pkg::sts_t                           sts_o,
  input  wire logic [agll_pkg::SAMPLE_W-1:0]       sample_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [agll_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [agll_pkg::CFG_W-1:0]          cfg_data_i,
  output logic [agll_pkg::OUT_TDATA_W-1:0]         out_data_o,
  output logic                                     out_sat_o
);

  localparam int SW = agll_pkg::SAMPLE_W;

  // coefficients
  logic signed [31:0] mean_q, ma_q, ar_q;
  logic [agll_pkg::COEF_W-1:0] gconst_q, arch_q, garch_q, initv_q;

  // series state
  logic signed [SW-1:0] x_q, ps_q;
  logic signed [agll_pkg::ERR_W-1:0] pe_q, e_q;
  logic [agll_pkg::VAR_W-1:0] pv_q;
  logic signed [agll_pkg::DER_W-1:0] ed_q [3];
  logic signed [agll_pkg::DER_W-1:0] vd_q [6];
  logic signed [agll_pkg::SUM_W-1:0] sum_q [6];
  logic sat_q;

  // per-sample scratch
  logic signed [63:0] s_q, esq_q, tmp_q, q_q, r_q, diff_q;
  logic [agll_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic out_sat_q;

  logic signed [63:0] mul_a, mul_b, mul_res;
  logic mul_sat, mul_done;
  logic [127:0] div_dvd;
  logic [63:0] div_quo;
  logic div_sat, div_done;

  logic [2:0] k3;
  logic [2:0] sk;
  logic [1:0] kk;
  logic signed [63:0] xs, add_a, add_b, xhat_err;
  agll_pkg::sat_t ad1, ad2, cl, ce, cs, fe;
  logic post_sat;
  logic [63:0] m_e;

  function automatic logic signed [63:0] pick(input agll_pkg::opsel_e sel);
    logic signed [63:0] v;
    case (sel)
      agll_pkg::OP_PE:    v = 64'(pe_q);
      agll_pkg::OP_PS:    v = 64'(ps_q);
      agll_pkg::OP_MA:    v = 64'(ma_q);
      agll_pkg::OP_AR:    v = 64'(ar_q);
      agll_pkg::OP_ARCH:  v = {33'd0, arch_q};
      agll_pkg::OP_GARCH: v = {33'd0, garch_q};
      agll_pkg::OP_TMP:   v = tmp_q;
      agll_pkg::OP_ESQ:   v = esq_q;
      agll_pkg::OP_PV:    v = {16'd0, pv_q};
      agll_pkg::OP_Q:     v = q_q;
      agll_pkg::OP_DIFF:  v = diff_q;
      agll_pkg::OP_EDK:   v = 64'(ed_q[kk]);
      agll_pkg::OP_VDK:   v = 64'(vd_q[{1'b0, kk}]);
      agll_pkg::OP_VDK3:  v = 64'(vd_q[k3]);
      default:            v = '0;
    endcase
    return v;
  endfunction

  assign kk = cmd_i.uop.k;
  assign k3 = {1'b0, kk} + 3'd3;
  // sums 3..5 belong to the variance-only parameters
  assign sk = (cmd_i.uop.post == agll_pkg::PO_SUM3) ? k3 : {1'b0, kk};

  always_comb begin
    mul_a = pick(cmd_i.uop.a);
    mul_b = pick(cmd_i.uop.b);
  end

  agll_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh_i    (cmd_i.uop.sh),
    .res_o   (mul_res),
    .sat_o   (mul_sat),
    .done_o  (mul_done)
  );

  assign m_e = agll_pkg::mag64(64'(e_q));
  assign div_dvd = cmd_i.div_sel ? (128'd1 << agll_pkg::VAR_W)
                                 : {56'd0, m_e[agll_pkg::ERR_W-1:0], 32'd0};

  agll_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (s_q[agll_pkg::VAR_W-1:0]),
    .quo_o   (div_quo),
    .sat_o   (div_sat),
    .done_o  (div_done)
  );

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;

  // post-operation arithmetic on a finished product
  always_comb begin
    xs = 64'(x_q);
    add_b = mul_res;
    case (cmd_i.uop.post)
      agll_pkg::PO_S1:  add_a = {33'd0, gconst_q};
      agll_pkg::PO_S2:  add_a = s_q;
      agll_pkg::PO_DE: begin
        case (kk)
          2'd0:    add_a = agll_pkg::ONE_Q16;
          2'd1:    add_a = 64'(pe_q);
          default: add_a = 64'(ps_q);
        endcase
      end
      agll_pkg::PO_DS3: begin
        case (kk)
          2'd0:    add_a = agll_pkg::ONE_Q16;
          2'd1:    add_a = esq_q;
          default: add_a = {16'd0, pv_q};
        endcase
      end
      agll_pkg::PO_QQ: begin
        add_a = r_q;
        add_b = -mul_res;
      end
      agll_pkg::PO_SUM3: add_a = '0;
      default: add_a = tmp_q;
    endcase
    ad1 = agll_pkg::add_sat(add_a, add_b);
    cl  = agll_pkg::clamp_w(ad1.v, agll_pkg::DER_W);
    ad2 = agll_pkg::add_sat(64'(sum_q[sk]), ad1.v);
    cs  = agll_pkg::clamp_w(ad2.v, agll_pkg::SUM_W);
    xhat_err = 64'(mean_q) + tmp_q + mul_res - xs;
    ce  = agll_pkg::clamp_w(xhat_err, agll_pkg::ERR_W);
    fe  = agll_pkg::clamp_w(64'sd0 - xs, agll_pkg::ERR_W);
    case (cmd_i.uop.post)
      agll_pkg::PO_XHAT:  post_sat = ce.sat;
      agll_pkg::PO_S1,
      agll_pkg::PO_S2,
      agll_pkg::PO_QQ:    post_sat = ad1.sat;
      agll_pkg::PO_DS,
      agll_pkg::PO_DE,
      agll_pkg::PO_DS3:   post_sat = ad1.sat | cl.sat;
      agll_pkg::PO_SUM,
      agll_pkg::PO_SUM3:  post_sat = ad1.sat | ad2.sat | cs.sat;
      default:            post_sat = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q   <= '0;
      ma_q     <= '0;
      ar_q     <= '0;
      gconst_q <= agll_pkg::COEF_W'(65536);
      arch_q   <= '0;
      garch_q  <= '0;
      initv_q  <= agll_pkg::COEF_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        agll_pkg::CFG_MEAN:   mean_q   <= cfg_data_i;
        agll_pkg::CFG_MA:     ma_q     <= cfg_data_i;
        agll_pkg::CFG_AR:     ar_q     <= cfg_data_i;
        agll_pkg::CFG_GCONST: gconst_q <= cfg_data_i[agll_pkg::COEF_W-1:0];
        agll_pkg::CFG_ARCH:   arch_q   <= cfg_data_i[agll_pkg::COEF_W-1:0];
        agll_pkg::CFG_GARCH:  garch_q  <= cfg_data_i[agll_pkg::COEF_W-1:0];
        agll_pkg::CFG_INITV:  initv_q  <= cfg_data_i[agll_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // series state and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q  <= '0;
      pe_q  <= '0;
      pv_q  <= agll_pkg::VAR_W'(65536);
      sat_q <= 1'b0;
      for (int i = 0; i < 3; i++) ed_q[i] <= '0;
      for (int i = 0; i < 6; i++) vd_q[i] <= '0;
      for (int i = 0; i < 6; i++) sum_q[i] <= '0;
    end else begin
      if (cmd_i.init_first) begin
        sat_q <= sat_q | fe.sat;
        for (int i = 0; i < 3; i++) ed_q[i] <= '0;
        for (int i = 0; i < 6; i++) vd_q[i] <= '0;
      end
      if (mul_done) begin
        sat_q <= sat_q | mul_sat | post_sat;
        case (cmd_i.uop.post)
          agll_pkg::PO_DS:  vd_q[{1'b0, kk}] <= cl.v[agll_pkg::DER_W-1:0];
          agll_pkg::PO_DE:  ed_q[kk] <= cl.v[agll_pkg::DER_W-1:0];
          agll_pkg::PO_DS3: vd_q[k3] <= cl.v[agll_pkg::DER_W-1:0];
          agll_pkg::PO_SUM,
          agll_pkg::PO_SUM3: sum_q[sk] <= cs.v[agll_pkg::SUM_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clamp_s && (s_q < 64'sd1 || s_q > agll_pkg::VAR_MAX)) begin
        sat_q <= 1'b1;
      end
      if (div_done) begin
        sat_q <= sat_q | div_sat;
      end
      if (cmd_i.fin) begin
        ps_q <= x_q;
        pe_q <= e_q;
        pv_q <= s_q[agll_pkg::VAR_W-1:0];
        if (cmd_i.last) begin
          sat_q <= 1'b0;
          for (int i = 0; i < 6; i++) sum_q[i] <= '0;
        end
      end
    end
  end

  // per-sample scratch and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_i;
    end
    if (cmd_i.init_first) begin
      e_q <= fe.v[agll_pkg::ERR_W-1:0];
      s_q <= {33'd0, initv_q};
    end
    if (mul_done) begin
      case (cmd_i.uop.post)
        agll_pkg::PO_ESQ:  esq_q <= mul_res;
        agll_pkg::PO_TMP:  tmp_q <= mul_res;
        agll_pkg::PO_XHAT: e_q <= ce.v[agll_pkg::ERR_W-1:0];
        agll_pkg::PO_S1,
        agll_pkg::PO_S2:   s_q <= ad1.v;
        agll_pkg::PO_QQ:   diff_q <= ad1.v;
        default: ;
      endcase
    end
    if (cmd_i.clamp_s) begin
      if (s_q < 64'sd1) begin
        s_q <= 64'sd1;
      end else if (s_q > agll_pkg::VAR_MAX) begin
        s_q <= agll_pkg::VAR_MAX;
      end
    end
    if (div_done) begin
      if (cmd_i.div_sel) begin
        r_q <= div_quo;
      end else begin
        q_q <= e_q[agll_pkg::ERR_W-1] ? -$signed(div_quo) : $signed(div_quo);
      end
    end
    if (cmd_i.fin && cmd_i.last) begin
      for (int i = 0; i < 6; i++) begin
        out_data_q[i*agll_pkg::GRAD_W +: agll_pkg::GRAD_W] <= 64'(sum_q[i]);
      end
      out_sat_q <= sat_q;
    end
  end

  assign out_data_o = out_data_q;
  assign out_sat_o  = out_sat_q;

endmodule

`default_nettype wire

// File: rtl/arma_garch_loglik_gradient_core.sv
// ----------------------------------------------------------------------------
// arma_garch_loglik_gradient_core - ARMA(1,1)-GARCH(1,1) likelihood gradient
// Runs the mean and variance recursions per sample, carries the parameter
// derivatives and emits six saturated gradient sums on the last sample.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: sample; tlast: last
//  m_axis    out        tdata: six Q32.32 gradient sums; tuser: saturated
//  cfg       in         write-only, index 0..6, 32-bit data
//
//  One sample at a time. The first sample of a series runs 10 products
//  through the shared multiplier, every later one 30; each sample also
//  takes two 128-step divisions by the variance in the serial divider.
//  Reset clears the series state, sums and coefficients to their defaults.
//  A result waits in the output register while the next sample is taken;
//  only the end of a following series stalls until that word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module arma_garch_loglik_gradient_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // sample (lowest bits up): sample
  input  wire logic [agll_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  input  wire logic                                  s_axis_tlast_i,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // grad_mean, grad_ma, grad_ar, grad_const, grad_arch, grad_garch
  output logic [agll_pkg::OUT_TDATA_W-1:0]           m_axis_tdata_o,
  // saturated
  output logic [0:0]                                 m_axis_tuser_o,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [agll_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [agll_pkg::CFG_W-1:0]            cfg_data_i
);

  agll_pkg::cmd_t cmd;
  agll_pkg::sts_t sts;
  logic out_sat;

  agll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // only the sample bits of tdata are used; padding bits are dropped
  agll_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_i   (s_axis_tdata_i[agll_pkg::SAMPLE_W-1:0]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata_o),
    .out_sat_o  (out_sat)
  );

  assign m_axis_tuser_o = out_sat;

endmodule

`default_nettype wire

// File: rtl/agll_checker.sv
// ----------------------------------------------------------------------------
// agll_checker - port-level checks
// Watches the stream ports of the gradient core over time.
// ----------------------------------------------------------------------------
`default_nettype none

module agll_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 s_axis_tvalid_i,
  input wire logic                                 s_axis_tready_o,
  input wire logic                                 m_axis_tvalid_o,
  input wire logic                                 m_axis_tready_i,
  input wire logic [agll_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  // a held result word keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // one sample at a time: busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a sample is in work");

  // a new result only comes out of the final step, never from idle
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a sample in work");

endmodule

bind arma_garch_loglik_gradient_core agll_checker u_agll_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// File: bench/arma_garch_loglik_gradient_core_tb.sv
// ----------------------------------------------------------------------------
// arma_garch_loglik_gradient_core_tb - self-checking bench for the gradient core
// Streams series of samples through the core and predicts each series'
// gradient word with a bit-true model of the recursion. Every received word
// is compared field by field. Runs a directed table first, then random series
// under several coefficient settings, with random idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module arma_garch_loglik_gradient_core_tb;
  import agll_pkg::*;

  // index that no register answers to
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 166;
  localparam int SETTLE_CYCLES = 600;
  localparam int LONG_HOLD = 4000;

  typedef struct packed {
    logic         sat;
    logic [383:0] gv;
  } grad_word_t;

  typedef struct packed {
    logic [31:0] smp;
    logic        lst;
    logic        zero_known;   // single-sample series: sums are plainly zero
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [0:0] m_axis_tuser_o;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  arma_garch_loglik_gradient_core u_top (
    .clk_i, .rst_ni,
    .s_axis_tdata_i, .s_axis_tlast_i, .s_axis_tvalid_i, .s_axis_tready_o,
    .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tvalid_o, .m_axis_tready_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Coefficient copies held by the bench
  logic signed [63:0] mu_r, ma_r, ar_r, omega_r, alpha_r, beta_r, v0_r;
  // Series state of the recursion
  logic signed [63:0] last_obs, last_err, last_var;
  logic signed [63:0] err_grad [3];
  logic signed [63:0] var_grad [6];
  logic signed [63:0] grad_acc [6];
  bit fresh_series, clip_seen;

  grad_word_t pending_grads [$];
  int errors = 0;
  int words_seen = 0;
  bit quiet = 1'b0;

  function automatic logic [63:0] magnitude(input logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      clip_seen = 1'b1;
      return S64_MAX;
    end
    if (t < -65'sh0_8000_0000_0000_0000) begin
      clip_seen = 1'b1;
      return S64_MIN;
    end
    return t[63:0];
  endfunction

  function automatic logic signed [63:0] clip(input logic signed [63:0] v, input int w);
    logic signed [63:0] lim;
    lim = (64'sd1 <<< (w - 1)) - 64'sd1;
    if (v > lim) begin
      clip_seen = 1'b1;
      return lim;
    end
    if (v < -lim - 64'sd1) begin
      clip_seen = 1'b1;
      return -lim - 64'sd1;
    end
    return v;
  endfunction

  // exact product, magnitude shifted right, clamped to +-(2^63-1)
  function automatic logic signed [63:0] mul_sh(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input int sh);
    logic [127:0] p;
    logic [63:0] m;
    p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> sh;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) begin
      clip_seen = 1'b1;
      m = S64_MAX;
    end else begin
      m = p[63:0];
    end
    return (a[63] != b[63]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] quot(input logic [127:0] num, input logic [63:0] d);
    logic [127:0] qt;
    qt = num / {64'd0, d};
    if (qt > 128'h7FFF_FFFF_FFFF_FFFF) begin
      clip_seen = 1'b1;
      return S64_MAX;
    end
    return qt[63:0];
  endfunction

  task automatic restart_series();
    for (int k = 0; k < 6; k++) grad_acc[k] = '0;
    fresh_series = 1'b1;
    clip_seen = 1'b0;
  endtask

  task automatic store_coef(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    case (idx)
      CFG_MEAN:   mu_r = {{32{v[31]}}, v};
      CFG_MA:     ma_r = {{32{v[31]}}, v};
      CFG_AR:     ar_r = {{32{v[31]}}, v};
      CFG_GCONST: omega_r = {33'd0, v[30:0]};
      CFG_ARCH:   alpha_r = {33'd0, v[30:0]};
      CFG_GARCH:  beta_r = {33'd0, v[30:0]};
      CFG_INITV:  v0_r = {33'd0, v[30:0]};
      default: ;
    endcase
  endtask

  // Advance the recursion by one sample; emit the sums on a last sample
  task automatic fold_sample(input logic [31:0] raw, input logic lst,
                             output bit emit, output grad_word_t res);
    logic signed [63:0] x, xhat, e, s, q, r, qq, diff, term, esq;
    logic signed [63:0] de [6];
    logic signed [63:0] ds [6];
    logic signed [63:0] eb [3];
    logic signed [63:0] sb [3];
    logic [63:0] m;
    x = {{32{raw[31]}}, raw};
    for (int k = 0; k < 6; k++) begin
      de[k] = '0;
      ds[k] = '0;
    end
    if (fresh_series) begin
      xhat = '0;
      s = v0_r;
    end else begin
      esq = mul_sh(last_err, last_err, 16);
      eb[0] = ONE_Q16; eb[1] = last_err; eb[2] = last_obs;
      sb[0] = ONE_Q16; sb[1] = esq;      sb[2] = last_var;
      xhat = mu_r + mul_sh(ma_r, last_err, 30) + mul_sh(ar_r, last_obs, 30);
      s = sadd(sadd(omega_r, mul_sh(alpha_r, esq, 30)), mul_sh(beta_r, last_var, 30));
      for (int k = 0; k < 3; k++) begin
        de[k] = clip(sadd(eb[k], mul_sh(ma_r, err_grad[k], 30)), DER_W);
        ds[k] = clip(sadd(mul_sh(alpha_r, mul_sh(last_err, err_grad[k], 15), 30),
                          mul_sh(beta_r, var_grad[k], 30)), DER_W);
        ds[k+3] = clip(sadd(sb[k], mul_sh(beta_r, var_grad[k+3], 30)), DER_W);
      end
    end
    e = clip(xhat - x, ERR_W);
    if (s < 64'sd1) begin
      clip_seen = 1'b1;
      s = 64'sd1;
    end
    if (s > VAR_MAX) begin
      clip_seen = 1'b1;
      s = VAR_MAX;
    end
    m = magnitude(e);
    q = quot({64'd0, m} << 32, s);
    if (e[63]) q = -q;
    r = quot(128'd1 << 48, s);
    qq = mul_sh(q, q, 32);
    diff = sadd(r, -qq);
    for (int k = 0; k < 6; k++) begin
      term = sadd(mul_sh(q, de[k], 15), mul_sh(ds[k], diff, 16));
      grad_acc[k] = sadd(grad_acc[k], term);
    end
    last_obs = x;
    last_err = e;
    last_var = s;
    for (int k = 0; k < 3; k++) err_grad[k] = de[k];
    for (int k = 0; k < 6; k++) var_grad[k] = ds[k];
    fresh_series = 1'b0;
    emit = lst;
    res.sat = clip_seen;
    for (int k = 0; k < 6; k++) res.gv[k*64 +: 64] = grad_acc[k];
    if (lst) restart_series();
  endtask

  // Offer one sample and hold it until the core takes it
  task automatic push_sample(input logic [31:0] raw, input logic lst, input bit zero_known);
    int gap;
    bit emit;
    grad_word_t res;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= raw;
    s_axis_tlast_i <= lst;
    do @(posedge clk_i); while (!s_axis_tready_o);
    fold_sample(raw, lst, emit, res);
    if (zero_known) begin
      res.gv = '0;
      res.sat = 1'b0;
    end
    if (emit) pending_grads.push_back(res);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk_i);
    // the core may still be folding a trailing sample
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coef(input int phase, input logic [CFG_IDX_W-1:0] idx);
    case (phase)
      1: return (idx <= CFG_AR) ? 32'h7FFF_FFFF : 32'h7FFF_FFFF;          // all at the top
      2: return (idx <= CFG_AR) ? 32'h8000_0000 :
                (idx == CFG_ARCH || idx == CFG_GARCH) ? 32'd0 : 32'd1;    // all at the bottom
      3: return $urandom();                                              // anything goes
      default: begin
        case (idx)
          CFG_MEAN:   return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
          CFG_MA, CFG_AR: return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
          CFG_GCONST: return $urandom_range(1, 32'h10_0000);
          CFG_ARCH:   return $urandom_range(0, 32'h1000_0000);
          CFG_GARCH:  return $urandom_range(0, 32'h2000_0000);
          default:    return $urandom_range(1, 32'h40_0000);
        endcase
      end
    endcase
  endfunction

  task automatic load_coefs(input int phase);
    logic [31:0] v;
    for (int i = 0; i < 7; i++) begin
      v = pick_coef(phase, i[CFG_IDX_W-1:0]);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[CFG_IDX_W-1:0];
      cfg_data_i <= v;
      @(posedge clk_i);
      store_coef(i[CFG_IDX_W-1:0], v);
    end
    if (phase == 1) begin
      // a write to an unused index must change nothing
      cfg_idx_i <= CFG_UNUSED;
      cfg_data_i <= $urandom();
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Directed samples, run under the reset coefficients
  dir_row_t dir_rows [] = '{
    '{32'h0000_0000, 1'b1, 1'b1},
    '{32'h7FFF_FFFF, 1'b1, 1'b1},
    '{32'h8000_0000, 1'b1, 1'b1},
    '{32'hFFFF_FFFF, 1'b1, 1'b1},
    '{32'h0001_0000, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0},
    '{32'hFFFF_0000, 1'b0, 1'b0},
    '{32'h0002_8000, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0}
  };

  // Stimulus: directed table, then random series per coefficient phase
  initial begin
    int left, len;
    logic [31:0] raw;
    mu_r = '0; ma_r = '0; ar_r = '0;
    omega_r = ONE_Q16; alpha_r = '0; beta_r = '0; v0_r = ONE_Q16;
    last_obs = '0; last_err = '0; last_var = ONE_Q16;
    for (int k = 0; k < 3; k++) err_grad[k] = '0;
    for (int k = 0; k < 6; k++) var_grad[k] = '0;
    restart_series();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) push_sample(dir_rows[i].smp, dir_rows[i].lst, dir_rows[i].zero_known);
    drain_results();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == NUM_PHASES - 1) quiet = 1'b1;
      load_coefs(phase);
      left = PHASE_ITEMS;
      while (left > 0) begin
        // mostly short series; now and then a long one
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
        if (len > left) len = left;
        for (int j = 0; j < len; j++) begin
          raw = ($urandom_range(0, 15) == 0) ? $urandom()
                                             : $urandom_range(0, 32'h8_0000) - 32'h4_0000;
          push_sample(raw, j == len - 1, 1'b0);
        end
        left -= len;
      end
      drain_results();
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: check each word, then decide whether to stall next cycle
  initial begin
    int stall;
    grad_word_t want;
    bit held_long;
    stall = 0;
    held_long = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        words_seen++;
        if (pending_grads.size() == 0) begin
          errors++;
          $display("%0t: unexpected gradient word %h", $time, m_axis_tdata_o);
        end else begin
          want = pending_grads.pop_front();
          for (int k = 0; k < NUM_GRAD; k++) begin
            if (m_axis_tdata_o[k*64 +: 64] !== want.gv[k*64 +: 64]) begin
              errors++;
              $display("%0t: gradient %0d expected %h actual %h", $time, k,
                       want.gv[k*64 +: 64], m_axis_tdata_o[k*64 +: 64]);
            end
          end
          if (m_axis_tuser_o[0] !== want.sat) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $time, want.sat,
                     m_axis_tuser_o[0]);
          end
        end
      end
      // hold off once for long enough that the input stalls
      if (!held_long && words_seen == 12) begin
        held_long = 1'b1;
        stall = LONG_HOLD;
      end else if (stall == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 6);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: arma_garch_loglik_gradient_core.f
rtl/agll_pkg.sv
rtl/agll_mul.sv
rtl/agll_div.sv
rtl/agll_ctrl.sv
rtl/agll_datapath.sv
rtl/arma_garch_loglik_gradient_core.sv
rtl/agll_checker.sv
bench/arma_garch_loglik_gradient_core_tb.sv
